FILE: rtl/soms_pkg.sv
// Shared types and constants for the sequence offset match map unit.
// Used by every module of the block; depends on nothing.
package soms_pkg;

  localparam int unsigned SymAw    = 16;
  localparam int unsigned SymDepth = 1 << SymAw;
  localparam int unsigned SymW     = 8;
  localparam int unsigned MaxRows  = 400;
  localparam int unsigned MaxLags  = 256;

  localparam int unsigned WidthW  = 12;
  localparam int unsigned OffW    = 12;
  localparam int unsigned LagW    = 9;
  localparam int unsigned ViewW   = 17;
  localparam int unsigned RowW    = 9;
  localparam int unsigned CountW  = 12;
  localparam int unsigned FracW   = 17;
  localparam int unsigned BaseW   = RowW + WidthW;
  localparam int unsigned DiffW   = ViewW + 2;
  localparam int unsigned StepW   = $clog2(FracW + 1);
  localparam int unsigned RegAw   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;
  localparam logic [1:0] RegLags   = 2'd2;
  localparam logic [1:0] RegView   = 2'd3;

  localparam logic [WidthW-1:0] WidthRst = WidthW'(1);
  localparam logic [OffW-1:0]   OffRst   = OffW'(0);
  localparam logic [LagW-1:0]   LagsRst  = LagW'(250);
  localparam logic [ViewW-1:0]  ViewRst  = ViewW'(0);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_READ,
    S_DRAIN,
    S_DIVGO,
    S_DIVW,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [WidthW-1:0] window_width;
    logic [OffW-1:0]   start_offset;
    logic [LagW-1:0]   lag_count;
    logic [ViewW-1:0]  view_length;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic in_ready;
    logic mem_re;
    logic div_start;
    logic out_load;
  } ctrl_t;

endpackage

FILE: rtl/soms_store.sv
// Symbol store: one write port, two registered read ports.
// Depends on soms_pkg for depth and symbol width.
module soms_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [soms_pkg::SymAw-1:0] waddr_i,
  input  logic [soms_pkg::SymW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [soms_pkg::SymAw-1:0] raddr_a_i,
  input  logic [soms_pkg::SymAw-1:0] raddr_b_i,
  output logic [soms_pkg::SymW-1:0]  rdata_a_o,
  output logic [soms_pkg::SymW-1:0]  rdata_b_o
);
  import soms_pkg::*;

  logic [SymW-1:0] mem_q [SymDepth];
  logic [SymW-1:0] rdata_a_q;
  logic [SymW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/soms_div.sv
// Restoring divider, one quotient bit per cycle: floor(count * 2^16 / divisor).
// Depends on soms_pkg; expects count not above divisor.
module soms_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [soms_pkg::CountW-1:0] count_i,
  input  logic [soms_pkg::WidthW-1:0] divisor_i,
  output logic [soms_pkg::FracW-1:0]  quot_o,
  output soms_pkg::div_stat_t         stat_o
);
  import soms_pkg::*;

  logic [WidthW:0]   rem_q, rem_d;
  logic [FracW-1:0]  quot_q, quot_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;
  logic [WidthW-1:0] rem_sub;

  always_comb begin
    ge      = rem_q >= {1'b0, divisor_i};
    rem_sub = ge ? WidthW'(rem_q - {1'b0, divisor_i}) : rem_q[WidthW-1:0];
    rem_d   = rem_q;
    quot_d  = quot_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = (WidthW + 1)'(count_i);
      quot_d = '0;
      step_d = StepW'(FracW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = {rem_sub, 1'b0};
      quot_d = {quot_q[FracW-2:0], ge};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/soms_cfg.sv
// Configuration registers behind an APB-style port, with read back.
// Depends on soms_pkg for register codes, widths and reset values.
module soms_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [soms_pkg::RegAw-1:0] paddr,
  input  logic [soms_pkg::DataW-1:0] pwdata,
  output logic [soms_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output soms_pkg::cfg_t             cfg_o
);
  import soms_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegWidth:  cfg_d.window_width = pwdata[WidthW-1:0];
        RegOffset: cfg_d.start_offset = pwdata[OffW-1:0];
        RegLags:   cfg_d.lag_count    = pwdata[LagW-1:0];
        RegView:   cfg_d.view_length  = pwdata[ViewW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegWidth:  prdata = DataW'(cfg_q.window_width);
      RegOffset: prdata = DataW'(cfg_q.start_offset);
      RegLags:   prdata = DataW'(cfg_q.lag_count);
      RegView:   prdata = DataW'(cfg_q.view_length);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_width <= WidthRst;
      cfg_q.start_offset <= OffRst;
      cfg_q.lag_count    <= LagsRst;
      cfg_q.view_length  <= ViewRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sequence_offset_match_map_unit.sv
// Top level: sequence self-match counter over a byte store, by row and lag.
// Depends on soms_pkg, soms_store, soms_div and soms_cfg.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | mode, address, symbol, row, lag
//   out     | output    | out_valid/out_ready| match_count, match_fraction, in_range
//   cfg     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// A load gives no result. A valid query reads the store one symbol pair
// per cycle over the window, then the divider forms the fraction bit by
// bit. A rejected query goes from the check straight to the output state
// without reading the store. Reset leaves the store contents undefined and
// the registers at their reset values. A stalled result holds in the output
// register; the unit takes a new item as long as it is idle.
module sequence_offset_match_map_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [soms_pkg::SymAw-1:0]  address_i,
  input  logic [soms_pkg::SymW-1:0]   symbol_i,
  input  logic [soms_pkg::RowW-1:0]   row_i,
  input  logic [soms_pkg::LagW-1:0]   lag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [soms_pkg::CountW-1:0] match_count_o,
  output logic [soms_pkg::FracW-1:0]  match_fraction_o,
  output logic                        in_range_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [soms_pkg::RegAw-1:0]  paddr,
  input  logic [soms_pkg::DataW-1:0]  pwdata,
  output logic [soms_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import soms_pkg::*;

  cfg_t              cfg;
  div_stat_t         div_st;
  ctrl_t             ctrl;
  state_e            state_q, state_d;

  logic [WidthW-1:0] w_eff;
  logic              in_acc, load_wr, query_acc;
  logic [RowW-1:0]   row_q;
  logic [LagW-1:0]   lag_q;
  logic [BaseW-1:0]  base_q, base_d;
  logic [DiffW-1:0]  diff_q, diff_d;
  logic [BaseW:0]    end_sum;
  logic              row_ok, lag_ok;
  logic [SymAw-1:0]  pa_q, pb_q;
  logic [WidthW-1:0] pos_q;
  logic              last;
  logic              rd_vld_q;
  logic [CountW-1:0] cnt_q;
  logic              in_range_q;
  logic [SymW-1:0]   rdata_a, rdata_b;
  logic [FracW-1:0]  quot;
  logic              out_valid_q;
  logic [CountW-1:0] match_count_q;
  logic [FracW-1:0]  match_fraction_q;
  logic              in_range_out_q;

  soms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  soms_store u_store (
    .clk_i     (clk_i),
    .we_i      (load_wr),
    .waddr_i   (address_i),
    .wdata_i   (symbol_i),
    .re_i      (ctrl.mem_re),
    .raddr_a_i (pa_q),
    .raddr_b_i (pb_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  soms_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.div_start),
    .count_i   (cnt_q),
    .divisor_i (w_eff),
    .quot_o    (quot),
    .stat_o    (div_st)
  );

  assign w_eff     = (cfg.window_width == '0) ? WidthW'(1) : cfg.window_width;
  assign in_ready_o = ctrl.in_ready;
  assign in_acc    = in_valid_i & in_ready_o;
  assign load_wr   = in_acc & ~mode_i;
  assign query_acc = in_acc & mode_i;

  assign base_d  = BaseW'(row_q) * BaseW'(w_eff);
  assign diff_d  = DiffW'(cfg.view_length) - DiffW'(cfg.lag_count)
                 - DiffW'(cfg.start_offset) - DiffW'(w_eff);
  assign end_sum = (BaseW + 1)'(base_q) + (BaseW + 1)'(w_eff);
  assign row_ok  = !diff_q[DiffW-1]
                 && (end_sum <= (BaseW + 1)'(diff_q[DiffW-2:0]))
                 && (row_q < RowW'(MaxRows));
  assign lag_ok  = (lag_q != '0) && (lag_q <= cfg.lag_count)
                 && (lag_q <= LagW'(MaxLags));
  assign last    = pos_q == (w_eff - WidthW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (query_acc) state_d = S_SETUP;
      S_SETUP: state_d = S_CHECK;
      S_CHECK: state_d = (row_ok && lag_ok) ? S_READ : S_OUT;
      S_READ:  if (last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (div_st.done) state_d = S_OUT;
      S_OUT:   if (ctrl.out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      S_IDLE:  ctrl.in_ready  = 1'b1;
      S_READ:  ctrl.mem_re    = 1'b1;
      S_DIVGO: ctrl.div_start = 1'b1;
      S_OUT:   ctrl.out_load  = !out_valid_q || out_ready_i;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= ctrl.mem_re;
      out_valid_q <= ctrl.out_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      row_q <= row_i;
      lag_q <= lag_i;
    end
    if (state_q == S_SETUP) begin
      base_q <= base_d;
      diff_q <= diff_d;
    end
    if (state_q == S_CHECK) begin
      in_range_q <= row_ok && lag_ok;
      cnt_q      <= '0;
      pos_q      <= '0;
      pa_q       <= base_q[SymAw-1:0];
      pb_q       <= base_q[SymAw-1:0] + SymAw'(lag_q) + SymAw'(cfg.start_offset);
    end
    if (ctrl.mem_re) begin
      pa_q  <= pa_q + SymAw'(1);
      pb_q  <= pb_q + SymAw'(1);
      pos_q <= pos_q + WidthW'(1);
    end
    if (rd_vld_q && (rdata_a == rdata_b)) begin
      cnt_q <= cnt_q + CountW'(1);
    end
    if (ctrl.out_load) begin
      match_count_q    <= cnt_q;
      match_fraction_q <= in_range_q ? quot : '0;
      in_range_out_q   <= in_range_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_count_o    = match_count_q;
  assign match_fraction_o = match_fraction_q;
  assign in_range_o       = in_range_out_q;

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (pos_q < w_eff))
    else $error("read position beyond window");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIVW))
    else $error("divider busy outside its wait state");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_load && !in_range_q) |-> (cnt_q == '0))
    else $error("rejected query carries a nonzero count");

endmodule
